@@ sv/rsi_pkg.sv @@
// Shared types, constants and helper functions for the ray/sphere intersection unit.
// No dependencies.
package rsi_pkg;

   localparam int DIR_FRAC_BITS = 16;
   localparam int SQRT_STAGES   = 16;
   localparam int NUM_STAGES    = SQRT_STAGES + 7;

   localparam logic [1:0] REG_CENTER_X = 2'd0;
   localparam logic [1:0] REG_CENTER_Y = 2'd1;
   localparam logic [1:0] REG_CENTER_Z = 2'd2;
   localparam logic [1:0] REG_RADIUS   = 2'd3;

   typedef struct packed {
      logic signed [31:0] value;
      logic               clamped;
   } clamp_type;

   typedef struct packed {
      logic [33:0]        rem;
      logic [31:0]        root;
      logic [63:0]        radicand;
      logic signed [31:0] h;
      logic               hit;
      logic               sat;
   } sqrt_type;

   function automatic clamp_type clamp32(input logic signed [63:0] x);
      clamp_type r;
      if (x > 64'sd2147483647) begin
         r.value   = 32'sh7FFFFFFF;
         r.clamped = 1'b1;
      end else if (x < -64'sd2147483648) begin
         r.value   = 32'sh80000000;
         r.clamped = 1'b1;
      end else begin
         r.value   = x[31:0];
         r.clamped = 1'b0;
      end
      return r;
   endfunction

   // one digit of the bitwise square root: two radicand bits in, one root bit out
   function automatic sqrt_type sqrt_step(input sqrt_type s);
      sqrt_type   r;
      logic [35:0] shifted;
      logic [35:0] trial;
      r        = s;
      shifted  = {s.rem, s.radicand[63:62]};
      trial    = {2'b00, s.root, 2'b01};
      if (shifted >= trial) begin
         r.rem  = 34'(shifted - trial);
         r.root = {s.root[30:0], 1'b1};
      end else begin
         r.rem  = shifted[33:0];
         r.root = {s.root[30:0], 1'b0};
      end
      r.radicand = {s.radicand[61:0], 2'b00};
      return r;
   endfunction

endpackage

@@ sv/ray_sphere_intersection_unit.sv @@
// Ray against sphere intersection, fully pipelined, one ray per clock while rsp_stall is low.
// Depends on rsi_pkg (types, clamp and square root step functions).
//
// Usage:
//  - req_*: one ray per word (origin Q16.16, unit direction Q1.16), valid/stall.
//  - rsp_*: one result word per ray: hit flag, chosen distance t, clamp flag.
//  - csr_*: register writes (index 0..2 center x/y/z, 3 radius), always ready.
//    Write registers only while no ray is in flight.
//  - 23 register stages; throughput is one ray per cycle while rsp_stall stays
//    low. Depth is set by the 16-stage square root (two root bits per stage)
//    plus seven arithmetic stages, each holding one layer of multipliers or one
//    wide add/compare.
//  - Every stage has its own valid bit; a stalled stage holds while empty
//    stages ahead of it keep filling, so rsp_stall only backs up the pipe
//    as far as needed and req_stall rises only when every stage is full.
//  - Synchronous active-high reset clears the valid bits and the registers
//    (center 0, radius 0).
module ray_sphere_intersection_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [17:0] req_dir_x,
   input  logic signed [17:0] req_dir_y,
   input  logic signed [17:0] req_dir_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_hit_distance,
   output logic               rsp_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int N  = rsi_pkg::NUM_STAGES;
   localparam int SQ = rsi_pkg::SQRT_STAGES;

   // configuration
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [30:0]        rad_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         cz_ff  <= '0;
         rad_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rsi_pkg::REG_CENTER_X: cx_ff  <= csr_data;
            rsi_pkg::REG_CENTER_Y: cy_ff  <= csr_data;
            rsi_pkg::REG_CENTER_Z: cz_ff  <= csr_data;
            rsi_pkg::REG_RADIUS:   rad_ff <= csr_data[30:0];
            default:               cx_ff  <= cx_ff;
         endcase
      end
   end

   // pipeline control
   logic [N-1:0] vld_ff;
   logic [N-1:0] en;

   always_comb begin
      en[N-1] = !vld_ff[N-1] || !rsp_stall;
      for (int k = N - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[N-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < N; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // stage A: v = origin - center, clamped
   logic signed [31:0] va_in [3];
   logic signed [31:0] va_ff [3];
   logic signed [17:0] da_ff [3];
   logic               sata_in, sata_ff;

   always_comb begin
      rsi_pkg::clamp_type cl [3];
      cl[0] = rsi_pkg::clamp32(64'(req_origin_x) - 64'(cx_ff));
      cl[1] = rsi_pkg::clamp32(64'(req_origin_y) - 64'(cy_ff));
      cl[2] = rsi_pkg::clamp32(64'(req_origin_z) - 64'(cz_ff));
      for (int i = 0; i < 3; i++) begin
         va_in[i] = cl[i].value;
      end
      sata_in = cl[0].clamped | cl[1].clamped | cl[2].clamped;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         va_ff   <= va_in;
         da_ff[0] <= req_dir_x;
         da_ff[1] <= req_dir_y;
         da_ff[2] <= req_dir_z;
         sata_ff <= sata_in;
      end
   end

   // stage B: products v*d and |v|^2
   logic signed [49:0] pb_in [3];
   logic signed [49:0] pb_ff [3];
   logic [63:0]        qb_in [3];
   logic [63:0]        qb_ff [3];
   logic               satb_ff;

   always_comb begin
      logic [31:0] m;
      for (int i = 0; i < 3; i++) begin
         m        = va_ff[i][31] ? 32'(-va_ff[i]) : 32'(va_ff[i]);
         pb_in[i] = 50'(va_ff[i]) * 50'(da_ff[i]);
         qb_in[i] = 64'(m) * 64'(m);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pb_ff   <= pb_in;
         qb_ff   <= qb_in;
         satb_ff <= sata_ff;
      end
   end

   // stage C: sums
   logic signed [51:0] dotc_in, dotc_ff;
   logic [63:0]        vsqc_in, vsqc_ff;
   logic               satc_ff;

   assign dotc_in = 52'(pb_ff[0]) + 52'(pb_ff[1]) + 52'(pb_ff[2]);
   assign vsqc_in = qb_ff[0] + qb_ff[1] + qb_ff[2];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         dotc_ff <= dotc_in;
         vsqc_ff <= vsqc_in;
         satc_ff <= satb_ff;
      end
   end

   // stage D: h = floor(dot / 2^16), clamped
   logic signed [31:0] hd_in, hd_ff;
   logic [31:0]        hmd_in, hmd_ff;
   logic               satd_in, satd_ff;
   logic [63:0]        vsqd_ff;

   always_comb begin
      rsi_pkg::clamp_type cl;
      cl      = rsi_pkg::clamp32(64'($signed(dotc_ff[51:rsi_pkg::DIR_FRAC_BITS])));
      hd_in   = cl.value;
      hmd_in  = cl.value[31] ? 32'(-cl.value) : 32'(cl.value);
      satd_in = satc_ff | cl.clamped;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         hd_ff   <= hd_in;
         hmd_ff  <= hmd_in;
         satd_ff <= satd_in;
         vsqd_ff <= vsqc_ff;
      end
   end

   // stage E: h^2 and r^2
   logic [63:0]        hhe_in, hhe_ff, rre_in, rre_ff, vsqe_ff;
   logic signed [31:0] he_ff;
   logic               sate_ff;

   assign hhe_in = 64'(hmd_ff) * 64'(hmd_ff);
   assign rre_in = 64'(rad_ff) * 64'(rad_ff);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         hhe_ff  <= hhe_in;
         rre_ff  <= rre_in;
         vsqe_ff <= vsqd_ff;
         he_ff   <= hd_ff;
         sate_ff <= satd_ff;
      end
   end

   // stage F: discriminant
   rsi_pkg::sqrt_type sqf_in, sqf_ff;

   always_comb begin
      logic [63:0] p;
      p               = hhe_ff + rre_ff;
      sqf_in.hit      = p >= vsqe_ff;
      sqf_in.radicand = sqf_in.hit ? p - vsqe_ff : 64'd0;
      sqf_in.rem      = '0;
      sqf_in.root     = '0;
      sqf_in.h        = he_ff;
      sqf_in.sat      = sate_ff;
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         sqf_ff <= sqf_in;
      end
   end

   // square root stages, two root bits each
   rsi_pkg::sqrt_type sq_in [SQ];
   rsi_pkg::sqrt_type sq_ff [SQ];

   always_comb begin
      for (int k = 0; k < SQ; k++) begin
         sq_in[k] = rsi_pkg::sqrt_step(rsi_pkg::sqrt_step(k == 0 ? sqf_ff : sq_ff[k-1]));
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SQ; k++) begin
         if (en[6 + k]) begin
            sq_ff[k] <= sq_in[k];
         end
      end
   end

   // output stage: choose root, clamp
   logic               hit_in, hit_ff, sat_in, sat_ff;
   logic signed [31:0] dist_in, dist_ff;

   always_comb begin
      rsi_pkg::sqrt_type  s;
      logic signed [33:0] nh, t0, t1, t;
      rsi_pkg::clamp_type cl;
      s   = sq_ff[SQ-1];
      nh  = -34'(s.h);
      t0  = nh - $signed({2'b00, s.root});
      t1  = nh + $signed({2'b00, s.root});
      t   = (t0 > 34'sd0 && t0 < t1) ? t0 : t1;
      cl  = rsi_pkg::clamp32(64'(t));
      hit_in  = s.hit;
      dist_in = s.hit ? cl.value : 32'sd0;
      sat_in  = s.sat | (s.hit & cl.clamped);
   end

   always_ff @(posedge clock) begin
      if (en[N-1]) begin
         hit_ff  <= hit_in;
         dist_ff <= dist_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_hit          = hit_ff;
   assign rsp_hit_distance = dist_ff;
   assign rsp_saturated    = sat_ff;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for ray_sphere_intersection_unit: random and directed rays,
// sphere registers changed between phases, results checked against an inline predictor.
// Depends on rsi_pkg and ray_sphere_intersection_unit.
class hit_scoreboard;
   typedef struct {
      logic               hit;
      logic signed [31:0] distance;
      logic               sat;
   } hit_word_type;

   hit_word_type pending[$];
   int errors;
   int checked;
   longint signed cx, cy, cz;
   longint unsigned rad;

   function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
         rsi_pkg::REG_CENTER_X: cx = longint'(signed'(data));
         rsi_pkg::REG_CENTER_Y: cy = longint'(signed'(data));
         rsi_pkg::REG_CENTER_Z: cz = longint'(signed'(data));
         default: rad = longint'(data[30:0]);
      endcase
   endfunction

   function longint signed sat32(longint signed x, inout bit flag);
      if (x > 64'sd2147483647) begin
         flag = 1;
         return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
         flag = 1;
         return -64'sd2147483648;
      end
      return x;
   endfunction

   function longint unsigned root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function void note_ray(logic signed [31:0] ox, oy, oz, logic signed [17:0] dx, dy, dz);
      bit sat;
      longint signed vx, vy, vz, dot, h, s, t0, t1, t;
      longint unsigned vsq, hm, p, m;
      hit_word_type w;
      sat = 0;
      vx = sat32(longint'(ox) - cx, sat);
      vy = sat32(longint'(oy) - cy, sat);
      vz = sat32(longint'(oz) - cz, sat);
      dot = vx * longint'(dx) + vy * longint'(dy) + vz * longint'(dz);
      vsq = 0;
      m = vx < 0 ? -vx : vx; vsq += m * m;
      m = vy < 0 ? -vy : vy; vsq += m * m;
      m = vz < 0 ? -vz : vz; vsq += m * m;
      h = dot >>> 16;
      h = sat32(h, sat);
      hm = h < 0 ? -h : h;
      p = hm * hm + rad * rad;
      if (p < vsq) begin
         w.hit = 0; w.distance = 0; w.sat = sat;
      end else begin
         s = longint'(root_floor(p - vsq));
         t0 = -h - s;
         t1 = -h + s;
         t = (t0 > 0 && t0 < t1) ? t0 : t1;
         t = sat32(t, sat);
         w.hit = 1; w.distance = t[31:0]; w.sat = sat;
      end
      pending.push_back(w);
   endfunction

   function void check_word(logic hit, logic signed [31:0] distance, logic sat);
      hit_word_type w;
      checked++;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result word hit=%0d t=%0d", hit, distance);
         return;
      end
      w = pending.pop_front();
      if (w.hit !== hit || w.distance !== distance || w.sat !== sat) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: exp hit=%0d t=%0d sat=%0d, got hit=%0d t=%0d sat=%0d",
                     w.hit, w.distance, w.sat, hit, distance, sat);
      end
   endfunction
endclass

module tb_top;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   logic signed [31:0] req_origin_x = 0, req_origin_y = 0, req_origin_z = 0;
   logic signed [17:0] req_dir_x = 0, req_dir_y = 0, req_dir_z = 0;
   logic rsp_valid, rsp_stall = 0, rsp_hit, rsp_saturated;
   logic signed [31:0] rsp_hit_distance;
   logic csr_valid = 0, csr_ready;
   logic [1:0] csr_index = 0;
   logic [31:0] csr_data = 0;

   hit_scoreboard sb;
   int cycles = 0;
   int rays = 0;
   bit draining = 0;

   ray_sphere_intersection_unit uut (.*);

   initial forever #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_hit, rsp_hit_distance, rsp_saturated);

   function int gap_len();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(negedge clock)
      if (draining || $urandom_range(0, 3) == 0) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(0, 99) < (cycles % 2000 < 300 ? 0 : 30));

   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1; csr_index <= idx; csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_sphere(logic [31:0] x, y, z, r);
      write_reg(rsi_pkg::REG_CENTER_X, x);
      write_reg(rsi_pkg::REG_CENTER_Y, y);
      write_reg(rsi_pkg::REG_CENTER_Z, z);
      write_reg(rsi_pkg::REG_RADIUS, r);
   endtask

   task automatic send_ray(logic signed [31:0] ox, oy, oz, logic signed [17:0] dx, dy, dz);
      int g;
      g = gap_len();
      repeat (g) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid <= 1;
      req_origin_x <= ox; req_origin_y <= oy; req_origin_z <= oz;
      req_dir_x <= dx; req_dir_y <= dy; req_dir_z <= dz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_ray(ox, oy, oz, dx, dy, dz);
      rays++;
      if ($urandom_range(0, 1) == 0) begin
         @(negedge clock);
         req_valid <= 0;
      end
   endtask

   task automatic idle_wait();
      @(negedge clock);
      req_valid <= 0;
      draining = 1;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (rsi_pkg::NUM_STAGES + 5) @(posedge clock);
      draining = 0;
   endtask

   function logic signed [17:0] rand_dir();
      case ($urandom_range(0, 5))
         0: return 18'sd65536;
         1: return -18'sd65536;
         2: return 18'($urandom);
         default: return 18'($signed($urandom_range(0, 131072)) - 65536);
      endcase
   endfunction

   function logic [31:0] rand_coord(int scale);
      case (scale)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh007FFFFF);
         default: return 32'($signed($urandom_range(0, 32'h000FFFFF)) - 32'sh0007FFFF);
      endcase
   endfunction

   task automatic random_phase(int n, int scale);
      logic signed [31:0] cxv, cyv, czv;
      logic signed [17:0] d;
      repeat (n) begin
         if ($urandom_range(0, 2) != 0) begin
            // aim from a point on the -z side roughly toward the center, with a small x/y tilt
            cxv = sb.cx[31:0]; cyv = sb.cy[31:0]; czv = sb.cz[31:0];
            d = rand_dir();
            send_ray(cxv + rand_coord(2) / 8, cyv + rand_coord(2) / 8,
                     czv - (rand_coord(2) & 32'h3FFFFFF),
                     18'($signed($urandom_range(0, 8000)) - 4000),
                     18'($signed($urandom_range(0, 8000)) - 4000),
                     (d < 0) ? -d : d);
         end else begin
            send_ray(rand_coord(scale), rand_coord(scale), rand_coord(scale),
                     rand_dir(), rand_dir(), rand_dir());
         end
      end
   endtask

   initial begin
      sb = new();
      sb.cx = 0; sb.cy = 0; sb.cz = 0; sb.rad = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      set_sphere(0, 0, 32'h000A0000, 32'h00030000);
      send_ray(0, 0, 0, 0, 0, 18'sd65536);
      send_ray(0, 0, 0, 0, 0, -18'sd65536);
      send_ray(0, 0, 32'h000A0000, 0, 0, 18'sd65536);
      send_ray(32'h00030000, 0, 0, 0, 0, 18'sd65536);
      send_ray(32'h00050000, 0, 0, 0, 0, 18'sd65536);
      send_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 18'sd65536, 18'sd65536, 18'sd65536);
      send_ray(32'h80000000, 32'h80000000, 32'h80000000, -18'sd65536, -18'sd65536, -18'sd65536);
      send_ray(32'h80000000, 32'h7FFFFFFF, 0, 18'h1FFFF, 18'h20000, 0);
      send_ray(0, 0, 0, 18'sd30000, 18'sd40000, 18'sd50000);
      idle_wait();

      set_sphere(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 18'sd65536, -18'sd65536, 18'sd65536);
      send_ray(0, 0, 0, 0, 0, 0);
      send_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 18'sd65536);
      random_phase(60, 0);
      idle_wait();

      set_sphere(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
      send_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 18'sd65536, 0);
      random_phase(40, 0);
      idle_wait();

      repeat (4) begin
         set_sphere(rand_coord(1), rand_coord(1), rand_coord(1),
                    $urandom_range(0, 32'h00400000));
         random_phase(90, 1 + $urandom_range(0, 1));
         idle_wait();
      end

      $display("%0d rays sent, %0d result words checked over several sphere settings",
               rays, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d words missing", sb.errors, sb.pending.size());
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
